[hdl/arp_pkg.sv]
// Shared types and constants for the ARP cache and responder.
// Holds the stream beat layouts, the table entry layout, the item modes and the
// sequencer states. Depends on nothing.
package arp_pkg;

    localparam int IP_BYTES  = 4;
    localparam int MAC_BYTES = 6;
    localparam int IP_W      = IP_BYTES * 8;
    localparam int MAC_W     = MAC_BYTES * 8;

    localparam logic [15:0] PTYPE_IPV4 = 16'h0800;
    localparam logic [15:0] OP_REQUEST = 16'd1;
    localparam logic [15:0] OP_REPLY   = 16'd2;

    typedef enum logic [1:0] {
        MODE_FRAME      = 2'd0,
        MODE_LOOKUP_IP  = 2'd1,
        MODE_LOOKUP_MAC = 2'd2,
        MODE_INVALIDATE = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        CFG_OWN_IP   = 2'd0,
        CFG_OWN_MAC  = 2'd1,
        CFG_ATTACHED = 2'd2
    } cfg_index_t;

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_SCAN  = 5'b00100,
        ST_ACT   = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    // Input beat, last listed field in the lowest bits.
    typedef struct packed {
        logic [MAC_W-1:0] key_mac;
        logic [IP_W-1:0]  key_ip;
        logic [IP_W-1:0]  target_ip;
        logic [IP_W-1:0]  sender_ip;
        logic [MAC_W-1:0] sender_mac;
        logic [15:0]      protocol_type;
        logic [15:0]      opcode;
    } in_beat_t;

    // Output beat, last listed field in the lowest bits, padded to whole bytes.
    typedef struct packed {
        logic [4:0]       pad;
        logic             table_full_drop;
        logic [IP_W-1:0]  result_ip;
        logic [MAC_W-1:0] result_mac;
        logic             found;
        logic [IP_W-1:0]  reply_target_ip;
        logic [MAC_W-1:0] reply_target_mac;
        logic             reply_valid;
    } out_beat_t;

    // One word of the table memory.
    typedef struct packed {
        logic             valid;
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
    } entry_t;

endpackage

[hdl/arp_cache_and_responder_top.sv]
// ARP cache and responder, top level.
// Depends on arp_pkg and arp_ram.
//
// Usage: each input beat on the s_ group carries one item; s_tuser gives its
// mode (received frame, lookup by IP, lookup by MAC, invalidate by IP) and
// s_tdata carries the parsed frame fields and lookup keys. Every item yields
// exactly one output beat on the m_ group. Registers own_ip, own_mac and
// attached are written through the cfg_ channel, which is always ready; own_mac
// is accepted but feeds no output.
// Sequence: an item that needs the table (a reply frame or lookup while
// attached, an invalidate) has the table memory scanned through its single read
// port, one entry per cycle; each entry is read into the memory's output
// register and compared, then the sequencer acts and loads the output register,
// which raises m_tvalid. Items that need no table access go straight to the
// output register. No new item is taken while one is being processed. A new
// item is accepted once the sequencer is back in idle, even if the previous
// output beat is still waiting in the output register.
// Reset: rst_n clears control state at once; every entry of the table memory
// is then swept to invalid, and no item is accepted until the sweep is done.
// Stalls: when m_tready is low, the finished result waits in the sequencer
// until the output register is free, and no further item is taken.
module arp_cache_and_responder_top #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    // Item stream.
    input  logic         s_tvalid,
    output logic         s_tready,
    // opcode, protocol_type, sender_mac, sender_ip, target_ip, key_ip, key_mac
    input  logic [223:0] s_tdata,
    // mode
    input  logic [1:0]   s_tuser,
    // Result stream.
    output logic         m_tvalid,
    input  logic         m_tready,
    // reply_valid, reply_target_mac, reply_target_ip, found, result_mac,
    // result_ip, table_full_drop, five zero bits
    output logic [167:0] m_tdata,
    // Configuration write channel.
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [47:0]  cfg_data
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
    localparam int ENTRY_W = $bits(arp_pkg::entry_t);

    arp_pkg::in_beat_t  in_beat;
    arp_pkg::entry_t    rd_entry;
    arp_pkg::entry_t    wr_entry;

    // Control state.
    arp_pkg::state_t    state_reg, state_next;
    logic [IDX_W-1:0]   rd_idx_reg, rd_idx_next;
    logic               issue_reg, issue_next;
    logic               cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]   cmp_idx_reg, cmp_idx_next;
    logic               hit_ip_reg, hit_ip_next;
    logic               hit_mac_reg, hit_mac_next;
    logic               free_reg, free_next;
    logic               out_vld_reg, out_vld_next;
    logic [arp_pkg::IP_W-1:0] own_ip_reg, own_ip_next;
    logic               attached_reg, attached_next;

    // Payload.
    arp_pkg::mode_t     mode_reg, mode_next;
    logic [arp_pkg::IP_W-1:0]  key_ip_reg, key_ip_next;
    logic [arp_pkg::MAC_W-1:0] key_mac_reg, key_mac_next;
    logic [arp_pkg::MAC_W-1:0] smac_reg, smac_next;
    logic [IDX_W-1:0]   hit_ip_idx_reg, hit_ip_idx_next;
    logic [arp_pkg::MAC_W-1:0] hit_ip_mac_reg, hit_ip_mac_next;
    logic [arp_pkg::IP_W-1:0]  hit_mac_ip_reg, hit_mac_ip_next;
    logic [IDX_W-1:0]   free_idx_reg, free_idx_next;
    arp_pkg::out_beat_t res_reg, res_next;
    arp_pkg::out_beat_t out_reg, out_next;

    // Memory port controls.
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0] ram_rdata;

    assign in_beat   = arp_pkg::in_beat_t'(s_tdata);
    assign rd_entry  = arp_pkg::entry_t'(ram_rdata);
    assign s_tready  = (state_reg == arp_pkg::ST_IDLE);
    assign m_tvalid  = out_vld_reg;
    assign m_tdata   = out_reg;
    assign cfg_ready = 1'b1;

    arp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (wr_entry),
        .raddr (rd_idx_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        rd_idx_next     = rd_idx_reg;
        issue_next      = issue_reg;
        cmp_vld_next    = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        hit_ip_next     = hit_ip_reg;
        hit_mac_next    = hit_mac_reg;
        free_next       = free_reg;
        out_vld_next    = out_vld_reg;
        own_ip_next     = own_ip_reg;
        attached_next   = attached_reg;
        mode_next       = mode_reg;
        key_ip_next     = key_ip_reg;
        key_mac_next    = key_mac_reg;
        smac_next       = smac_reg;
        hit_ip_idx_next = hit_ip_idx_reg;
        hit_ip_mac_next = hit_ip_mac_reg;
        hit_mac_ip_next = hit_mac_ip_reg;
        free_idx_next   = free_idx_reg;
        res_next        = res_reg;
        out_next        = out_reg;
        ram_we          = 1'b0;
        ram_waddr       = rd_idx_reg;
        wr_entry        = '0;

        if (out_vld_reg && m_tready)
        begin
            out_vld_next = 1'b0;
        end

        if (cfg_valid)
        begin
            unique case (arp_pkg::cfg_index_t'(cfg_index))
                arp_pkg::CFG_OWN_IP:   own_ip_next = cfg_data[arp_pkg::IP_W-1:0];
                arp_pkg::CFG_OWN_MAC:  ;  // stored nowhere: no output depends on it
                arp_pkg::CFG_ATTACHED: attached_next = cfg_data[0];
                default:               ;
            endcase
        end

        unique case (state_reg)
            arp_pkg::ST_CLEAR:
            begin
                // Sweep every entry to invalid after reset.
                ram_we    = 1'b1;
                ram_waddr = rd_idx_reg;
                if (rd_idx_reg == LAST_IDX)
                begin
                    rd_idx_next = '0;
                    state_next  = arp_pkg::ST_IDLE;
                end
                else
                begin
                    rd_idx_next = rd_idx_reg + IDX_W'(1);
                end
            end

            arp_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    mode_next    = arp_pkg::mode_t'(s_tuser);
                    smac_next    = in_beat.sender_mac;
                    key_mac_next = in_beat.key_mac;
                    key_ip_next  = (arp_pkg::mode_t'(s_tuser) == arp_pkg::MODE_FRAME) ?
                                   in_beat.sender_ip : in_beat.key_ip;
                    res_next     = '0;
                    hit_ip_next  = 1'b0;
                    hit_mac_next = 1'b0;
                    free_next    = 1'b0;
                    rd_idx_next  = '0;
                    issue_next   = 1'b1;
                    state_next   = arp_pkg::ST_DONE;
                    unique case (arp_pkg::mode_t'(s_tuser))
                        arp_pkg::MODE_FRAME:
                        begin
                            if (attached_reg && in_beat.protocol_type == arp_pkg::PTYPE_IPV4)
                            begin
                                if (in_beat.opcode == arp_pkg::OP_REQUEST)
                                begin
                                    if (in_beat.target_ip == own_ip_reg)
                                    begin
                                        res_next.reply_valid      = 1'b1;
                                        res_next.reply_target_mac = in_beat.sender_mac;
                                        res_next.reply_target_ip  = in_beat.sender_ip;
                                    end
                                end
                                else if (in_beat.opcode == arp_pkg::OP_REPLY)
                                begin
                                    state_next = arp_pkg::ST_SCAN;
                                end
                            end
                        end
                        arp_pkg::MODE_LOOKUP_IP,
                        arp_pkg::MODE_LOOKUP_MAC:
                        begin
                            if (attached_reg)
                            begin
                                state_next = arp_pkg::ST_SCAN;
                            end
                        end
                        arp_pkg::MODE_INVALIDATE:
                        begin
                            state_next = arp_pkg::ST_SCAN;
                        end
                        default: ;
                    endcase
                end
            end

            arp_pkg::ST_SCAN:
            begin
                // Read one entry per cycle; compare the entry read in the previous cycle.
                if (issue_reg)
                begin
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = rd_idx_reg;
                    if (rd_idx_reg == LAST_IDX)
                    begin
                        issue_next = 1'b0;
                    end
                    else
                    begin
                        rd_idx_next = rd_idx_reg + IDX_W'(1);
                    end
                end
                if (cmp_vld_reg)
                begin
                    // Only the lowest-numbered match or free entry is kept.
                    if (!hit_ip_reg && rd_entry.valid && rd_entry.ip == key_ip_reg)
                    begin
                        hit_ip_next     = 1'b1;
                        hit_ip_idx_next = cmp_idx_reg;
                        hit_ip_mac_next = rd_entry.mac;
                    end
                    if (!hit_mac_reg && rd_entry.valid && rd_entry.mac == key_mac_reg)
                    begin
                        hit_mac_next    = 1'b1;
                        hit_mac_ip_next = rd_entry.ip;
                    end
                    if (!free_reg && !rd_entry.valid)
                    begin
                        free_next     = 1'b1;
                        free_idx_next = cmp_idx_reg;
                    end
                    if (cmp_idx_reg == LAST_IDX)
                    begin
                        state_next = arp_pkg::ST_ACT;
                    end
                end
            end

            arp_pkg::ST_ACT:
            begin
                state_next = arp_pkg::ST_DONE;
                unique case (mode_reg)
                    arp_pkg::MODE_FRAME:
                    begin
                        // Reply frame: overwrite the matching entry, else take
                        // the lowest free one, else drop it.
                        wr_entry.valid = 1'b1;
                        wr_entry.ip    = key_ip_reg;
                        wr_entry.mac   = smac_reg;
                        if (hit_ip_reg)
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = hit_ip_idx_reg;
                        end
                        else if (free_reg)
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = free_idx_reg;
                        end
                        else
                        begin
                            res_next.table_full_drop = 1'b1;
                        end
                    end
                    arp_pkg::MODE_LOOKUP_IP:
                    begin
                        res_next.found = hit_ip_reg;
                        if (hit_ip_reg)
                        begin
                            res_next.result_mac = hit_ip_mac_reg;
                        end
                    end
                    arp_pkg::MODE_LOOKUP_MAC:
                    begin
                        res_next.found = hit_mac_reg;
                        if (hit_mac_reg)
                        begin
                            res_next.result_ip = hit_mac_ip_reg;
                        end
                    end
                    arp_pkg::MODE_INVALIDATE:
                    begin
                        res_next.found = hit_ip_reg;
                        ram_we         = hit_ip_reg;
                        ram_waddr      = hit_ip_idx_reg;
                    end
                    default: ;
                endcase
            end

            arp_pkg::ST_DONE:
            begin
                if (!out_vld_reg || m_tready)
                begin
                    out_next     = res_reg;
                    out_vld_next = 1'b1;
                    state_next   = arp_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = arp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= arp_pkg::ST_CLEAR;
            rd_idx_reg   <= '0;
            issue_reg    <= 1'b0;
            cmp_vld_reg  <= 1'b0;
            cmp_idx_reg  <= '0;
            hit_ip_reg   <= 1'b0;
            hit_mac_reg  <= 1'b0;
            free_reg     <= 1'b0;
            out_vld_reg  <= 1'b0;
            own_ip_reg   <= '0;
            attached_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_idx_reg   <= rd_idx_next;
            issue_reg    <= issue_next;
            cmp_vld_reg  <= cmp_vld_next;
            cmp_idx_reg  <= cmp_idx_next;
            hit_ip_reg   <= hit_ip_next;
            hit_mac_reg  <= hit_mac_next;
            free_reg     <= free_next;
            out_vld_reg  <= out_vld_next;
            own_ip_reg   <= own_ip_next;
            attached_reg <= attached_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        key_ip_reg     <= key_ip_next;
        key_mac_reg    <= key_mac_next;
        smac_reg       <= smac_next;
        hit_ip_idx_reg <= hit_ip_idx_next;
        hit_ip_mac_reg <= hit_ip_mac_next;
        hit_mac_ip_reg <= hit_mac_ip_next;
        free_idx_reg   <= free_idx_next;
        res_reg        <= res_next;
        out_reg        <= out_next;
    end

endmodule

[hdl/arp_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stands alone; used for the ARP table.
module arp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[test/tb.sv]
// Self-checking testbench for the ARP cache and responder top level.
// Drives items and register writes, predicts every result beat and compares them.
// Depends on arp_pkg and the arp_cache_and_responder_top RTL.
module tb;

    localparam int NUM_ENTRIES = 16;
    localparam int IP_POOL     = 24;
    localparam int MAC_POOL    = 10;
    localparam int MAX_PRINTS  = 40;

    // Index 3 names no register; a write to it must change nothing.
    localparam logic [1:0] CFG_SPARE = 2'd3;

    logic         clk       = 1'b0;
    logic         rst_n     = 1'b0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    // opcode, protocol_type, sender_mac, sender_ip, target_ip, key_ip, key_mac
    logic [223:0] s_tdata   = '0;
    // mode
    logic [1:0]   s_tuser   = '0;
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    // reply_valid, reply_target_mac, reply_target_ip, found, result_mac,
    // result_ip, table_full_drop, five zero bits
    logic [167:0] m_tdata;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [1:0]   cfg_index = '0;
    logic [47:0]  cfg_data  = '0;

    // Our own copy of the station registers and the address table.
    logic [31:0] my_ip   = '0;
    logic [47:0] my_mac  = '0;
    logic        link_up = 1'b0;
    bit          cache_valid [NUM_ENTRIES];
    logic [31:0] cache_ip    [NUM_ENTRIES];
    logic [47:0] cache_mac   [NUM_ENTRIES];

    // Result beats still owed by the block, oldest first.
    arp_pkg::out_beat_t expected_beats [$];

    // Addresses that the stimulus keeps reusing so that the table fills up,
    // lookups hit and several entries share one MAC.
    logic [31:0] ip_pool  [IP_POOL];
    logic [47:0] mac_pool [MAC_POOL];

    int error_count  = 0;
    int result_count = 0;
    int stall_left   = 0;
    bit gaps_on      = 1'b1;

    arp_pkg::out_beat_t got_beat;
    arp_pkg::out_beat_t want_beat;

    arp_cache_and_responder_top #(
        .TABLE_ENTRIES(NUM_ENTRIES)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #5 clk = ~clk;

    // A hard stop well beyond the slowest correct run, in case a handshake hangs.
    initial
    begin
        #4_000_000;
        $display("tb: done, errors");
        $finish;
    end

    function automatic logic [47:0] rand48();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[47:0];
    endfunction

    function automatic logic [15:0] rand16();
        logic [31:0] w;
        w = $urandom;
        return w[15:0];
    endfunction

    // Idle length in cycles: mostly none, often a few, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // A parsed frame; the lookup keys are filled with noise.
    function automatic arp_pkg::in_beat_t frame_beat(input logic [15:0] op,
                                                     input logic [15:0] ptype,
                                                     input logic [47:0] smac,
                                                     input logic [31:0] sip,
                                                     input logic [31:0] tip);
        arp_pkg::in_beat_t b;
        b.opcode        = op;
        b.protocol_type = ptype;
        b.sender_mac    = smac;
        b.sender_ip     = sip;
        b.target_ip     = tip;
        b.key_ip        = $urandom;
        b.key_mac       = rand48();
        return b;
    endfunction

    // A lookup or invalidate; the frame fields are filled with noise.
    function automatic arp_pkg::in_beat_t key_beat(input logic [31:0] kip,
                                                   input logic [47:0] kmac);
        arp_pkg::in_beat_t b;
        b.opcode        = rand16();
        b.protocol_type = rand16();
        b.sender_mac    = rand48();
        b.sender_ip     = $urandom;
        b.target_ip     = $urandom;
        b.key_ip        = kip;
        b.key_mac       = kmac;
        return b;
    endfunction

    // Index of the valid entry that holds ip, or -1.
    function automatic int slot_of_ip(input logic [31:0] ip);
        for (int i = 0; i < NUM_ENTRIES; i++)
            if (cache_valid[i] && cache_ip[i] == ip)
                return i;
        return -1;
    endfunction

    // Works out the result beat of one item and applies its effect on the table.
    function automatic arp_pkg::out_beat_t resolve_item(input arp_pkg::mode_t m,
                                                        input arp_pkg::in_beat_t b);
        arp_pkg::out_beat_t r;
        int slot;
        r = '0;
        slot = -1;
        case (m)
            arp_pkg::MODE_FRAME:
            begin
                if (link_up && b.protocol_type == arp_pkg::PTYPE_IPV4)
                begin
                    if (b.opcode == arp_pkg::OP_REQUEST)
                    begin
                        if (b.target_ip == my_ip)
                        begin
                            r.reply_valid      = 1'b1;
                            r.reply_target_mac = b.sender_mac;
                            r.reply_target_ip  = b.sender_ip;
                        end
                    end
                    else if (b.opcode == arp_pkg::OP_REPLY)
                    begin
                        // Overwrite a known address, else take the lowest free entry.
                        slot = slot_of_ip(b.sender_ip);
                        for (int i = 0; i < NUM_ENTRIES && slot < 0; i++)
                            if (!cache_valid[i])
                                slot = i;
                        if (slot < 0)
                            r.table_full_drop = 1'b1;
                        else
                        begin
                            cache_valid[slot] = 1'b1;
                            cache_ip[slot]    = b.sender_ip;
                            cache_mac[slot]   = b.sender_mac;
                        end
                    end
                end
            end
            arp_pkg::MODE_LOOKUP_IP:
            begin
                if (link_up)
                    slot = slot_of_ip(b.key_ip);
                if (slot >= 0)
                begin
                    r.found      = 1'b1;
                    r.result_mac = cache_mac[slot];
                end
            end
            arp_pkg::MODE_LOOKUP_MAC:
            begin
                // The lowest entry with a matching MAC wins.
                for (int i = NUM_ENTRIES - 1; i >= 0; i--)
                    if (link_up && cache_valid[i] && cache_mac[i] == b.key_mac)
                        slot = i;
                if (slot >= 0)
                begin
                    r.found     = 1'b1;
                    r.result_ip = cache_ip[slot];
                end
            end
            default:
            begin
                // Invalidation works whether or not a network is attached.
                slot = slot_of_ip(b.key_ip);
                if (slot >= 0)
                begin
                    cache_valid[slot] = 1'b0;
                    r.found           = 1'b1;
                end
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        if (error_count < MAX_PRINTS)
            $display("tb: mismatch at result %0d: %s", result_count, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    // Sends one item beat. The valid line is only dropped when a gap follows, so a
    // back-to-back beat never sees valid lowered and raised in one time step.
    task automatic send_item(input arp_pkg::mode_t m, input arp_pkg::in_beat_t b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= m;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_beats.push_back(resolve_item(m, b));
    endtask

    // Stops sending and waits until every owed result beat has come back.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_beats.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [47:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            arp_pkg::CFG_OWN_IP:   my_ip   = data[31:0];
            arp_pkg::CFG_OWN_MAC:  my_mac  = data;
            arp_pkg::CFG_ATTACHED: link_up = data[0];
            default:               ;
        endcase
    endtask

    // Writes all three registers and then the unused index, which must be ignored.
    // Called only when no result is owed, the first time while the table is still being cleared.
    task automatic configure(input logic [47:0] ip_word, input logic [47:0] mac_word,
                             input logic [47:0] att_word);
        write_reg(arp_pkg::CFG_OWN_IP, ip_word);
        write_reg(arp_pkg::CFG_OWN_MAC, mac_word);
        write_reg(arp_pkg::CFG_ATTACHED, att_word);
        write_reg(CFG_SPARE, rand48());
        cfg_valid <= 1'b0;
    endtask

    // With no network attached, frames are ignored, lookups miss and an invalidate is still handled.
    task automatic test_detached();
        configure(48'h0, 48'h0, 48'hFFFF_FFFF_FFFE);
        send_item(arp_pkg::MODE_FRAME, frame_beat(arp_pkg::OP_REPLY, arp_pkg::PTYPE_IPV4,
                                                  mac_pool[4], ip_pool[4], $urandom));
        send_item(arp_pkg::MODE_FRAME, frame_beat(arp_pkg::OP_REQUEST, arp_pkg::PTYPE_IPV4,
                                                  rand48(), $urandom, 32'h0));
        send_item(arp_pkg::MODE_LOOKUP_IP, key_beat(ip_pool[4], rand48()));
        send_item(arp_pkg::MODE_LOOKUP_MAC, key_beat($urandom, mac_pool[4]));
        send_item(arp_pkg::MODE_INVALIDATE, key_beat(ip_pool[4], rand48()));
        wait_for_results();
    endtask

    // Requests for our address are answered; everything else stays silent.
    task automatic test_responder();
        configure({16'hFFFF, 32'hFFFF_FFFF}, 48'hFFFF_FFFF_FFFF, 48'h1);
        send_item(arp_pkg::MODE_FRAME, frame_beat(arp_pkg::OP_REQUEST, arp_pkg::PTYPE_IPV4,
                                                  48'hFFFF_FFFF_FFFF, 32'h0, 32'hFFFF_FFFF));
        send_item(arp_pkg::MODE_FRAME, frame_beat(arp_pkg::OP_REQUEST, arp_pkg::PTYPE_IPV4,
                                                  48'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        // A request for some other station.
        send_item(arp_pkg::MODE_FRAME, frame_beat(arp_pkg::OP_REQUEST, arp_pkg::PTYPE_IPV4,
                                                  rand48(), $urandom, 32'hFFFF_FFFE));
        // Right target, but not an IPv4 frame.
        send_item(arp_pkg::MODE_FRAME, frame_beat(arp_pkg::OP_REQUEST, 16'hFFFF,
                                                  rand48(), $urandom, 32'hFFFF_FFFF));
        // Right target, but an operation that is neither request nor reply.
        send_item(arp_pkg::MODE_FRAME, frame_beat(16'h0, arp_pkg::PTYPE_IPV4,
                                                  rand48(), $urandom, 32'hFFFF_FFFF));
        send_item(arp_pkg::MODE_FRAME, frame_beat(16'hFFFF, arp_pkg::PTYPE_IPV4,
                                                  rand48(), $urandom, 32'hFFFF_FFFF));
        wait_for_results();
    endtask

    // Fills the table, overflows it, overwrites, looks up both ways and invalidates;
    // then looks up by IP and invalidates while detached.
    task automatic test_table();
        for (int k = 0; k < NUM_ENTRIES; k++)
            send_item(arp_pkg::MODE_FRAME,
                      frame_beat(arp_pkg::OP_REPLY, arp_pkg::PTYPE_IPV4,
                                 mac_pool[k % MAC_POOL], ip_pool[k], $urandom));
        // A known address gets a new MAC; a new address finds no room.
        send_item(arp_pkg::MODE_FRAME, frame_beat(arp_pkg::OP_REPLY, arp_pkg::PTYPE_IPV4,
                                                  mac_pool[9], ip_pool[5], $urandom));
        send_item(arp_pkg::MODE_FRAME, frame_beat(arp_pkg::OP_REPLY, arp_pkg::PTYPE_IPV4,
                                                  mac_pool[6], ip_pool[16], $urandom));
        send_item(arp_pkg::MODE_LOOKUP_IP, key_beat(ip_pool[5], rand48()));
        // Two entries carry this MAC; the lower one must answer.
        send_item(arp_pkg::MODE_LOOKUP_MAC, key_beat($urandom, mac_pool[1]));
        send_item(arp_pkg::MODE_LOOKUP_MAC, key_beat($urandom, mac_pool[2]));
        // Freeing an entry lets the next new address in.
        send_item(arp_pkg::MODE_INVALIDATE, key_beat(ip_pool[3], rand48()));
        send_item(arp_pkg::MODE_FRAME, frame_beat(arp_pkg::OP_REPLY, arp_pkg::PTYPE_IPV4,
                                                  mac_pool[3], ip_pool[17], $urandom));
        send_item(arp_pkg::MODE_LOOKUP_IP, key_beat(ip_pool[17], rand48()));
        wait_for_results();
        configure({16'h0, $urandom}, 48'h0, 48'h0);
        send_item(arp_pkg::MODE_LOOKUP_IP, key_beat(ip_pool[0], rand48()));
        send_item(arp_pkg::MODE_INVALIDATE, key_beat(ip_pool[0], rand48()));
        wait_for_results();
        configure({16'h0, $urandom}, rand48(), 48'h1);
        send_item(arp_pkg::MODE_LOOKUP_IP, key_beat(ip_pool[0], rand48()));
        wait_for_results();
    endtask

    // Random traffic: mostly well-formed frames and lookups on the shared address
    // pools, some noise. At item pause_at the sender holds off until all results
    // are back.
    task automatic run_traffic(input int count, input int pause_at);
        arp_pkg::in_beat_t b;
        arp_pkg::mode_t    m;
        int                pick;
        int                op_pick;
        logic [31:0]       kip;
        logic [47:0]       kmac;
        for (int n = 0; n < count; n++)
        begin
            if (n == pause_at)
                wait_for_results();
            pick = $urandom_range(0, 99);
            kip  = ($urandom_range(0, 6) != 0) ? ip_pool[$urandom_range(0, IP_POOL - 1)]
                                               : $urandom;
            kmac = ($urandom_range(0, 6) != 0) ? mac_pool[$urandom_range(0, MAC_POOL - 1)]
                                               : rand48();
            if (pick < 50)
            begin
                m = arp_pkg::MODE_FRAME;
                op_pick = $urandom_range(0, 19);
                if (op_pick < 9)
                    b = frame_beat(arp_pkg::OP_REQUEST, arp_pkg::PTYPE_IPV4, rand48(),
                                   $urandom, ($urandom_range(0, 2) != 0) ? my_ip : kip);
                else if (op_pick < 18)
                    b = frame_beat(arp_pkg::OP_REPLY, arp_pkg::PTYPE_IPV4, kmac, kip,
                                   $urandom);
                else if (op_pick == 18)
                    b = frame_beat(rand16(), arp_pkg::PTYPE_IPV4, kmac, kip, my_ip);
                else
                    b = frame_beat(($urandom_range(0, 1) != 0) ? arp_pkg::OP_REQUEST
                                                               : arp_pkg::OP_REPLY,
                                   rand16(), kmac, kip, my_ip);
            end
            else
            begin
                if (pick < 70)
                    m = arp_pkg::MODE_LOOKUP_IP;
                else if (pick < 85)
                    m = arp_pkg::MODE_LOOKUP_MAC;
                else
                    m = arp_pkg::MODE_INVALIDATE;
                b = key_beat(kip, kmac);
            end
            send_item(m, b);
        end
        wait_for_results();
    endtask

    // Several register settings in turn, the extremes among them, with one phase
    // that runs without any idle cycles on either side.
    task automatic test_random_traffic();
        configure({16'hFFFF, $urandom}, rand48(), 48'h1);
        run_traffic(240, 120);
        configure({16'hFFFF, 32'h0}, 48'h0, 48'hFFFF_FFFF_FFFF);
        gaps_on = 1'b0;
        run_traffic(200, -1);
        gaps_on = 1'b1;
        configure({16'h0, 32'hFFFF_FFFF}, 48'hFFFF_FFFF_FFFF, 48'h0);
        run_traffic(60, -1);
        configure(rand48(), rand48(), 48'h1);
        run_traffic(220, -1);
    endtask

    // The result side stalls at random: most stalls are short, a few are long.
    always @(posedge clk)
    begin
        if (stall_left > 0)
            stall_left--;
        else if (gaps_on && $urandom_range(0, 3) == 0)
            stall_left = pick_gap();
        m_tready <= (stall_left == 0);
    end

    // Every accepted result beat is compared field by field with the oldest
    // expectation. Values are sampled at the edge, before any update it causes.
    always @(posedge clk)
    begin
        if (m_tvalid === 1'b1 && m_tready)
        begin
            got_beat = m_tdata;
            if (expected_beats.size() == 0)
                report_mismatch("result beat with nothing expected");
            else
            begin
                want_beat = expected_beats.pop_front();
                check_field("reply_valid", got_beat.reply_valid, want_beat.reply_valid);
                check_field("reply_target_mac", got_beat.reply_target_mac,
                            want_beat.reply_target_mac);
                check_field("reply_target_ip", got_beat.reply_target_ip,
                            want_beat.reply_target_ip);
                check_field("found", got_beat.found, want_beat.found);
                check_field("result_mac", got_beat.result_mac, want_beat.result_mac);
                check_field("result_ip", got_beat.result_ip, want_beat.result_ip);
                check_field("table_full_drop", got_beat.table_full_drop,
                            want_beat.table_full_drop);
                check_field("padding", got_beat.pad, want_beat.pad);
            end
            result_count++;
        end
    end

    initial
    begin
        for (int k = 0; k < IP_POOL; k++)
            ip_pool[k] = $urandom;
        for (int k = 0; k < MAC_POOL; k++)
            mac_pool[k] = rand48();
        // Put the extreme addresses into the table as well.
        ip_pool[0]  = 32'h0;
        ip_pool[15] = 32'hFFFF_FFFF;
        mac_pool[0] = 48'hFFFF_FFFF_FFFF;
        mac_pool[2] = 48'h0;

        // Reset is applied once. The block then clears its table and holds
        // s_tready low until it is done, which send_item simply waits out.
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_detached();
        test_responder();
        test_table();
        test_random_traffic();

        // Any stray beat in this window is reported by the checker.
        repeat (NUM_ENTRIES + 8) @(posedge clk);
        if (error_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

[sim.f]
hdl/arp_pkg.sv
hdl/arp_ram.sv
hdl/arp_cache_and_responder_top.sv
test/tb.sv
